// ===== src/ehpd_pkg.sv =====
// Package for the extruder heater PD control unit.
// Holds the field widths, mode and register codes, reset values and shared structs.
// It has no dependencies. The top level and the update stage import it.
package ehpd_pkg;

  // Field widths.
  localparam int unsigned TempW    = 13;
  localparam int unsigned DutyW    = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned ErrW     = 14;  // setpoint - measured, signed
  localparam int unsigned PrevErrW = 15;  // held error, signed
  localparam int unsigned ProdPW   = 31;  // err * kp, signed
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ModeW    = 2;

  // The compare value that turns the heater off.
  localparam logic [DutyW-1:0] DUTY_OFF = 16'hFFFF;

  // Result mode codes.
  localparam logic [ModeW-1:0] MODE_DISABLED  = 2'd0;
  localparam logic [ModeW-1:0] MODE_OVERSHOOT = 2'd1;
  localparam logic [ModeW-1:0] MODE_BOOST     = 2'd2;
  localparam logic [ModeW-1:0] MODE_PD        = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KP           = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_KD           = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_SETPOINT = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_DUTY_FLOOR   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_BOOST_DUTY   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_BAND  = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_COOL_BAND    = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_BOOST_BAND   = 4'd7;

  // Configuration reset values.
  localparam logic [GainW-1:0] KP_RESET           = 16'd150;
  localparam logic [GainW-1:0] KD_RESET           = 16'd7000;
  localparam logic [TempW-1:0] MIN_SETPOINT_RESET = 13'd2400;
  localparam logic [DutyW-1:0] DUTY_FLOOR_RESET   = 16'd55000;
  localparam logic [DutyW-1:0] BOOST_DUTY_RESET   = 16'd50000;
  localparam logic [TempW-1:0] SETTLE_BAND_RESET  = 13'd32;
  localparam logic [TempW-1:0] COOL_BAND_RESET    = 13'd80;
  localparam logic [TempW-1:0] BOOST_BAND_RESET   = 13'd320;

  // Configuration register file contents.
  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] kd;
    logic [TempW-1:0] min_setpoint;
    logic [DutyW-1:0] duty_floor;
    logic [DutyW-1:0] boost_duty;
    logic [TempW-1:0] settle_band;
    logic [TempW-1:0] cool_band;
    logic [TempW-1:0] boost_band;
  } cfg_t;

  // One tick after the input register: enable flag, error and proportional product.
  typedef struct packed {
    logic                     enable;
    logic signed [ErrW-1:0]   err;
    logic signed [ProdPW-1:0] prod_p;
  } item_t;

  // Loop state carried from tick to tick.
  typedef struct packed {
    logic [DutyW-1:0]           duty;
    logic signed [PrevErrW-1:0] prev_err;
    logic [CntW-1:0]            settle_cnt;
  } loop_state_t;

endpackage

// ===== src/ehpd_pd_step.sv =====
// Update stage of the extruder heater PD control unit.
// Combinational: from one registered tick and the loop state it forms the next state and mode.
// Depends on ehpd_pkg.
module ehpd_pd_step import ehpd_pkg::*; (
  input  cfg_t             cfg_i,
  input  item_t            item_i,
  input  loop_state_t      state_i,
  output loop_state_t      state_o,
  output logic [ModeW-1:0] mode_o
);

  logic [TempW-1:0]           mag;
  logic                       in_band;
  logic signed [PrevErrW-1:0] err_ext;
  logic signed [PrevErrW-1:0] cool_neg;
  logic signed [PrevErrW-1:0] boost_lim;
  logic                       overshoot;
  logic                       boost;
  logic signed [15:0]         diff;
  logic signed [16:0]         kd_s;
  logic signed [32:0]         prod_d;
  logic signed [32:0]         num;
  logic signed [32:0]         num_adj;
  logic signed [32:0]         delta;
  logic signed [33:0]         nd;
  logic [DutyW-1:0]           pd_duty;

  // Error magnitude and band tests.
  assign mag       = item_i.err[ErrW-1] ? TempW'(-item_i.err) : item_i.err[TempW-1:0];
  assign in_band   = (mag < cfg_i.settle_band);
  assign err_ext   = PrevErrW'(item_i.err);
  assign cool_neg  = -$signed({2'b00, cfg_i.cool_band});
  assign boost_lim = $signed({2'b00, cfg_i.boost_band});
  assign overshoot = (err_ext < cool_neg);
  assign boost     = (err_ext > boost_lim);

  // Incremental PD step: the derivative product, less the registered proportional product.
  assign diff    = 16'(state_i.prev_err) - 16'(item_i.err);
  assign kd_s    = $signed({1'b0, cfg_i.kd});
  assign prod_d  = 33'(diff) * 33'(kd_s);
  assign num     = prod_d - 33'(item_i.prod_p);
  // Divide by 16 with truncation toward zero.
  assign num_adj = num + (num[32] ? 33'sd15 : 33'sd0);
  assign delta   = num_adj >>> 4;
  assign nd      = $signed({18'd0, state_i.duty}) + 34'(delta);

  // Clamp to [duty_floor, off]; a negative sum always falls below the floor.
  always_comb begin
    if (nd < $signed({18'd0, cfg_i.duty_floor})) begin
      pd_duty = cfg_i.duty_floor;
    end else if (nd > $signed({18'd0, DUTY_OFF})) begin
      pd_duty = DUTY_OFF;
    end else begin
      pd_duty = nd[DutyW-1:0];
    end
  end

  // Case selection.
  always_comb begin
    state_o = state_i;
    mode_o  = MODE_DISABLED;
    if (!item_i.enable) begin
      state_o.duty = DUTY_OFF;
      mode_o       = MODE_DISABLED;
    end else begin
      if (in_band) begin
        if (state_i.settle_cnt != {CntW{1'b1}}) begin
          state_o.settle_cnt = state_i.settle_cnt + 1'b1;
        end
      end else begin
        state_o.settle_cnt = '0;
      end
      if (overshoot) begin
        state_o.duty = DUTY_OFF;
        mode_o       = MODE_OVERSHOOT;
      end else if (boost) begin
        state_o.duty = cfg_i.boost_duty;
        mode_o       = MODE_BOOST;
      end else begin
        state_o.duty     = pd_duty;
        state_o.prev_err = err_ext;
        mode_o           = MODE_PD;
      end
    end
  end

endmodule

// ===== src/extruder_heater_pd_control_unit.sv =====
// Extruder heater PD control unit: two-register pipeline from input transfer to result.
// Flow: a tick loads the input register at its input transfer, then the result register
// once that is free, and transfers out when the output is ready. Throughput: one tick per
// cycle unless the output stalls; the update register closes the duty and error loop.
// Reset: pipeline valid flags, duty, held error and settle counter clear to zero; the
// configuration registers return to their default gains, bands and duty limits.
// Depends on ehpd_pkg and ehpd_pd_step.
module extruder_heater_pd_control_unit import ehpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TempW-1:0]    setpoint_i,
  input  logic [TempW-1:0]    measured_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DutyW-1:0]    duty_o,
  output logic [CntW-1:0]     settle_count_o,
  output logic [ModeW-1:0]    mode_o
);

  cfg_t             cfg_q;
  logic             s1_valid_q;
  item_t            s1_item_q;
  item_t            s1_item_d;
  logic             out_valid_q;
  logic [ModeW-1:0] mode_q;
  logic [ModeW-1:0] mode_d;
  loop_state_t      state_q;
  loop_state_t      state_d;
  logic             out_free;
  logic             s1_adv;
  logic             in_xfer;
  logic signed [16:0] kp_s;

  // Configuration register file; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp           <= KP_RESET;
      cfg_q.kd           <= KD_RESET;
      cfg_q.min_setpoint <= MIN_SETPOINT_RESET;
      cfg_q.duty_floor   <= DUTY_FLOOR_RESET;
      cfg_q.boost_duty   <= BOOST_DUTY_RESET;
      cfg_q.settle_band  <= SETTLE_BAND_RESET;
      cfg_q.cool_band    <= COOL_BAND_RESET;
      cfg_q.boost_band   <= BOOST_BAND_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KP:           cfg_q.kp           <= cfg_data_i;
        REG_KD:           cfg_q.kd           <= cfg_data_i;
        REG_MIN_SETPOINT: cfg_q.min_setpoint <= cfg_data_i[TempW-1:0];
        REG_DUTY_FLOOR:   cfg_q.duty_floor   <= cfg_data_i;
        REG_BOOST_DUTY:   cfg_q.boost_duty   <= cfg_data_i;
        REG_SETTLE_BAND:  cfg_q.settle_band  <= cfg_data_i[TempW-1:0];
        REG_COOL_BAND:    cfg_q.cool_band    <= cfg_data_i[TempW-1:0];
        REG_BOOST_BAND:   cfg_q.boost_band   <= cfg_data_i[TempW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: the result register frees when empty or when its transfer completes.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input stage: enable test, error and the proportional product.
  assign kp_s             = $signed({1'b0, cfg_q.kp});
  assign s1_item_d.enable = (setpoint_i >= cfg_q.min_setpoint);
  assign s1_item_d.err    = $signed({1'b0, setpoint_i}) - $signed({1'b0, measured_i});
  assign s1_item_d.prod_p = ProdPW'(s1_item_d.err) * ProdPW'(kp_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= s1_item_d;
    end
  end

  // Update stage.
  ehpd_pd_step u_pd_step (
    .cfg_i   (cfg_q),
    .item_i  (s1_item_q),
    .state_i (state_q),
    .state_o (state_d),
    .mode_o  (mode_d)
  );

  // Loop state doubles as the result register for duty and settle count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mode_q <= mode_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_o         = state_q.duty;
  assign settle_count_o = state_q.settle_cnt;
  assign mode_o         = mode_q;

endmodule

// ===== src/ehpd_checker.sv =====
// Port-level checker for the extruder heater PD control unit, with its bind statement.
// Depends on ehpd_pkg and on the top level's port names.
module ehpd_checker import ehpd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DutyW-1:0] duty_o,
  input logic [ModeW-1:0] mode_o
);

  // A disabled heater always shows the off compare value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_DISABLED)) |-> (duty_o == DUTY_OFF))
    else $error("disabled result without off duty");

  // An overshoot always shows the off compare value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_OVERSHOOT)) |-> (duty_o == DUTY_OFF))
    else $error("overshoot result without off duty");

  // The input side only stalls while a result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && in_valid_i) |-> out_valid_o)
    else $error("input stalled with an empty output register");

  // A stalled result holds its duty and mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(duty_o) && $stable(mode_o)))
    else $error("stalled result changed");

endmodule

bind extruder_heater_pd_control_unit ehpd_checker u_ehpd_checker (.*);

// ===== sim/extruder_heater_pd_control_unit_tb.sv =====
// Self-checking testbench for the extruder heater PD control unit.
// Drives directed and random ticks through several gain and band settings and checks
// every result against an in-bench PD predictor or a typed-in result. Depends on ehpd_pkg and the unit RTL.
module extruder_heater_pd_control_unit_tb;
  import ehpd_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 60;
  localparam int MaxReports    = 10;
  localparam int NumDirected   = 21;
  localparam int TempMax       = (1 << TempW) - 1;
  localparam int InBandTicks   = 40;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [CntW-1:0]  settle;
    logic [ModeW-1:0] mode;
  } heater_out_t;

  // One directed tick; the result is typed in only where it is obvious.
  typedef struct packed {
    logic             typed;
    logic [TempW-1:0] sp;
    logic [TempW-1:0] ms;
    heater_out_t      out;
  } directed_row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [TempW-1:0]    setpoint_i     = '0;
  logic [TempW-1:0]    measured_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [DutyW-1:0]    duty_o;
  logic [CntW-1:0]     settle_count_o;
  logic [ModeW-1:0]    mode_o;

  extruder_heater_pd_control_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .setpoint_i     (setpoint_i),
    .measured_i     (measured_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .duty_o         (duty_o),
    .settle_count_o (settle_count_o),
    .mode_o         (mode_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the configuration and the loop state.
  cfg_t             settings;
  logic [DutyW-1:0] pd_duty;
  int               pd_prev_err;
  logic [CntW-1:0]  pd_settle;

  heater_out_t predicted_q [$];
  int          src_max_gap   = 6;
  int          snk_max_gap   = 6;
  bit          hold_off_req  = 1'b0;
  int          fail_count    = 0;
  int          report_count  = 0;
  int          tick_count    = 0;
  int          cfg_writes    = 0;
  int          mode_hits [4] = '{0, 0, 0, 0};
  int          stall_cycles  = 0;

  // Directed ticks at the reset settings: bounds of every band, field extremes and
  // a disabled tick that must leave the settle counter alone.
  directed_row_t directed_rows [NumDirected] = '{
    '{1'b1, 13'd0,    13'd0,    '{DUTY_OFF,   16'd0, MODE_DISABLED}},
    '{1'b1, 13'd2399, 13'd8191, '{DUTY_OFF,   16'd0, MODE_DISABLED}},
    '{1'b1, 13'd8191, 13'd0,    '{16'd50000,  16'd0, MODE_BOOST}},
    '{1'b1, 13'd2400, 13'd8191, '{DUTY_OFF,   16'd0, MODE_OVERSHOOT}},
    '{1'b1, 13'd2400, 13'd2400, '{DUTY_OFF,   16'd1, MODE_PD}},
    '{1'b1, 13'd2400, 13'd2400, '{DUTY_OFF,   16'd2, MODE_PD}},
    '{1'b1, 13'd100,  13'd5000, '{DUTY_OFF,   16'd2, MODE_DISABLED}},
    '{1'b1, 13'd4000, 13'd4031, '{DUTY_OFF,   16'd3, MODE_PD}},
    '{1'b0, 13'd4000, 13'd3969, '0},
    '{1'b0, 13'd4000, 13'd3968, '0},
    '{1'b0, 13'd4000, 13'd4032, '0},
    '{1'b0, 13'd4000, 13'd3680, '0},
    '{1'b1, 13'd4000, 13'd3679, '{16'd50000,  16'd0, MODE_BOOST}},
    '{1'b0, 13'd4000, 13'd4080, '0},
    '{1'b1, 13'd4000, 13'd4081, '{DUTY_OFF,   16'd0, MODE_OVERSHOOT}},
    '{1'b0, 13'd8191, 13'd8191, '0},
    '{1'b0, 13'd2400, 13'd2080, '0},
    '{1'b1, 13'd5461, 13'd2730, '{16'd50000,  16'd0, MODE_BOOST}},
    '{1'b1, 13'd2730, 13'd5461, '{DUTY_OFF,   16'd0, MODE_OVERSHOOT}},
    '{1'b0, 13'd3000, 13'd3000, '0},
    '{1'b0, 13'd3000, 13'd3001, '0}
  };

  // One control tick of the incremental PD loop; updates the predictor state.
  function automatic heater_out_t pd_tick(input logic [TempW-1:0] sp,
                                          input logic [TempW-1:0] ms);
    heater_out_t r;
    int          err;
    int          mag;
    longint      step;
    longint      next;
    if (sp < settings.min_setpoint) begin
      pd_duty = DUTY_OFF;
      r.mode  = MODE_DISABLED;
    end else begin
      err = int'(sp) - int'(ms);
      mag = (err < 0) ? -err : err;
      // Settle counter saturates, and clears on any tick outside the band.
      if (mag < int'(settings.settle_band)) begin
        if (pd_settle != '1) pd_settle = pd_settle + 1'b1;
      end else begin
        pd_settle = '0;
      end
      if (err < -int'(settings.cool_band)) begin
        pd_duty = DUTY_OFF;
        r.mode  = MODE_OVERSHOOT;
      end else if (err > int'(settings.boost_band)) begin
        pd_duty = settings.boost_duty;
        r.mode  = MODE_BOOST;
      end else begin
        // Signed division truncates toward zero; the floor wins over the ceiling.
        step = longint'(pd_prev_err - err) * longint'(settings.kd)
             - longint'(err) * longint'(settings.kp);
        next = longint'(pd_duty) + step / 16;
        if (next > longint'(DUTY_OFF)) next = longint'(DUTY_OFF);
        if (next < longint'(settings.duty_floor)) next = longint'(settings.duty_floor);
        pd_duty     = next[DutyW-1:0];
        pd_prev_err = err;
        r.mode      = MODE_PD;
      end
    end
    r.duty   = pd_duty;
    r.settle = pd_settle;
    return r;
  endfunction

  // Offer one tick after a random gap and record its prediction on transfer.
  task automatic send_tick(input logic [TempW-1:0] sp, input logic [TempW-1:0] ms,
                           input logic typed, input heater_out_t typed_out);
    int          gap;
    heater_out_t res;
    gap = $urandom_range(0, src_max_gap);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measured_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    res = pd_tick(sp, ms);
    predicted_q.push_back(typed ? typed_out : res);
    tick_count++;
  endtask

  // One register write transfer; the predictor copy follows it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KP:           settings.kp           = data;
      REG_KD:           settings.kd           = data;
      REG_MIN_SETPOINT: settings.min_setpoint = data[TempW-1:0];
      REG_DUTY_FLOOR:   settings.duty_floor   = data;
      REG_BOOST_DUTY:   settings.boost_duty   = data;
      REG_SETTLE_BAND:  settings.settle_band  = data[TempW-1:0];
      REG_COOL_BAND:    settings.cool_band    = data[TempW-1:0];
      REG_BOOST_BAND:   settings.boost_band   = data[TempW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write all registers, with junk in the bits above the narrow ones, plus one
  // write to an index past the register map.
  task automatic load_settings(input cfg_t s);
    logic [CfgDataW-TempW-1:0] pad;
    write_reg(REG_KP, s.kp);
    write_reg(REG_KD, s.kd);
    pad = (CfgDataW-TempW)'($urandom);
    write_reg(REG_MIN_SETPOINT, {pad, s.min_setpoint});
    write_reg(REG_DUTY_FLOOR, s.duty_floor);
    write_reg(REG_BOOST_DUTY, s.boost_duty);
    pad = (CfgDataW-TempW)'($urandom);
    write_reg(REG_SETTLE_BAND, {pad, s.settle_band});
    pad = (CfgDataW-TempW)'($urandom);
    write_reg(REG_COOL_BAND, {pad, s.cool_band});
    pad = (CfgDataW-TempW)'($urandom);
    write_reg(REG_BOOST_BAND, {pad, s.boost_band});
    write_reg(REG_BOOST_BAND + CfgIdxW'($urandom_range(1, 8)), CfgDataW'($urandom));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random ticks: mostly enabled setpoints with a measured value near them, the rest
  // fully random. Idling changes every fifty ticks.
  task automatic random_ticks(input int count, input bit pressure);
    int               span;
    int               d;
    int               msv;
    logic [TempW-1:0] sp;
    logic [TempW-1:0] ms;
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        src_max_gap = $urandom_range(0, 1) ? 6 : 0;
        snk_max_gap = $urandom_range(0, 1) ? 6 : 0;
        if (pressure && k == 0) begin
          src_max_gap  = 0;
          hold_off_req = 1'b1;
        end
      end
      if ($urandom_range(0, 9) < 6) begin
        sp   = TempW'($urandom_range(int'(settings.min_setpoint), TempMax));
        span = ((settings.cool_band > settings.boost_band) ?
                int'(settings.cool_band) : int'(settings.boost_band)) + 4;
        if (span > TempMax) span = TempMax;
        d   = int'($urandom_range(0, 2 * span)) - span;
        msv = int'(sp) - d;
        if (msv < 0) msv = 0;
        if (msv > TempMax) msv = TempMax;
        ms  = TempW'(msv);
      end else begin
        sp = TempW'($urandom);
        ms = TempW'($urandom);
      end
      send_tick(sp, ms, 1'b0, '0);
    end
  endtask

  // Result side: random ready gaps, one long hold-off on request, and the checks.
  initial begin
    int          gap;
    heater_out_t got;
    heater_out_t want;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(0, snk_max_gap);
      if (hold_off_req) begin
        gap          = HoldOffCycles;
        hold_off_req = 1'b0;
      end
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{duty_o, settle_count_o, mode_o};
      mode_hits[got.mode]++;
      if (predicted_q.size() == 0) begin
        fail_count++;
        if (report_count++ < MaxReports)
          $display("ERROR: unexpected result duty=%0d settle=%0d mode=%0d",
                   got.duty, got.settle, got.mode);
      end else begin
        want = predicted_q.pop_front();
        if (got.duty !== want.duty || got.settle !== want.settle || got.mode !== want.mode) begin
          fail_count++;
          if (report_count++ < MaxReports)
            $display("ERROR: result mismatch, expected duty=%0d settle=%0d mode=%0d,",
                     want.duty, want.settle, want.mode,
                     " got duty=%0d settle=%0d mode=%0d",
                     got.duty, got.settle, got.mode);
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("ERROR: no transfer for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    cfg_t s;
    settings = '{kp: KP_RESET, kd: KD_RESET, min_setpoint: MIN_SETPOINT_RESET,
                 duty_floor: DUTY_FLOOR_RESET, boost_duty: BOOST_DUTY_RESET,
                 settle_band: SETTLE_BAND_RESET, cool_band: COOL_BAND_RESET,
                 boost_band: BOOST_BAND_RESET};
    pd_duty     = '0;
    pd_prev_err = 0;
    pd_settle   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at the reset settings.
    for (int i = 0; i < NumDirected; i++)
      send_tick(directed_rows[i].sp, directed_rows[i].ms, directed_rows[i].typed,
                directed_rows[i].out);
    drain_results();

    // Highest gains, lowest floor and widest bands: every enabled tick is a PD step.
    s = '{kp: 16'hFFFF, kd: 16'hFFFF, min_setpoint: '0, duty_floor: '0,
          boost_duty: 16'hFFFF, settle_band: '1, cool_band: '1, boost_band: '1};
    load_settings(s);
    random_ticks(180, 1'b0);
    drain_results();

    // Everything zero: only a zero error reaches the PD step.
    s = '0;
    load_settings(s);
    random_ticks(180, 1'b0);
    drain_results();

    // Moderate settings, with the output held off so the input backs up.
    s = '{kp: 16'd600, kd: 16'd2000, min_setpoint: 13'd1000, duty_floor: 16'd20000,
          boost_duty: 16'd10000, settle_band: 13'd16, cool_band: 13'd200,
          boost_band: 13'd500};
    load_settings(s);
    random_ticks(180, 1'b1);
    drain_results();

    // Random settings.
    s.kp           = GainW'($urandom);
    s.kd           = GainW'($urandom);
    s.min_setpoint = TempW'($urandom);
    s.duty_floor   = DutyW'($urandom);
    s.boost_duty   = DutyW'($urandom);
    s.settle_band  = TempW'($urandom);
    s.cool_band    = TempW'($urandom);
    s.boost_band   = TempW'($urandom);
    load_settings(s);
    random_ticks(180, 1'b0);
    drain_results();

    // Back to the defaults; a run of in-band ticks at full rate counts the settle counter up.
    s = '{kp: KP_RESET, kd: KD_RESET, min_setpoint: MIN_SETPOINT_RESET,
          duty_floor: DUTY_FLOOR_RESET, boost_duty: BOOST_DUTY_RESET,
          settle_band: SETTLE_BAND_RESET, cool_band: COOL_BAND_RESET,
          boost_band: BOOST_BAND_RESET};
    load_settings(s);
    src_max_gap = 0;
    snk_max_gap = 0;
    for (int i = 0; i < InBandTicks; i++)
      send_tick(13'd4000, 13'd4000, 1'b0, '0);
    random_ticks(140, 1'b0);
    drain_results();
    repeat (8) @(posedge clk_i);

    if (predicted_q.size() != 0) begin
      fail_count += predicted_q.size();
      $display("ERROR: %0d results never arrived", predicted_q.size());
    end
    $display("Ran %0d control ticks and %0d register writes over six settings,",
             tick_count, cfg_writes);
    $display("modes seen: disabled %0d, overshoot %0d, boost %0d, PD %0d; failures %0d.",
             mode_hits[MODE_DISABLED], mode_hits[MODE_OVERSHOOT], mode_hits[MODE_BOOST],
             mode_hits[MODE_PD], fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
